### sv/tccw_pkg.sv
// Package with the item types, action codes and character constants of the text console writer.
`timescale 1ns / 1ps

package tccw_pkg;

    // Default screen geometry.
    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    // Widths of the result fields and of the cell address field on the ports.
    localparam int COL_FIELD_W = 7;
    localparam int ROW_FIELD_W = 5;
    localparam int POS_FIELD_W = 11;
    localparam int ADR_FIELD_W = 11;

    // Action codes.
    localparam logic [1:0] ACT_PUT   = 2'd0;
    localparam logic [1:0] ACT_CLEAR = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    // Character codes with a meaning of their own.
    localparam logic [7:0] CHAR_SPACE     = 8'h20;
    localparam logic [7:0] CHAR_NEWLINE   = 8'd10;
    localparam logic [7:0] CHAR_BACKSPACE = 8'd8;

    // Attribute that reset gives to the color register and to every cell.
    localparam logic [7:0] RESET_COLOR = 8'h0F;

    typedef struct packed {
        logic [1:0]             action;
        logic [7:0]             char_code;
        logic [ADR_FIELD_W-1:0] cell_address;
    } t_item;

    typedef struct packed {
        logic [COL_FIELD_W-1:0] cursor_column;
        logic [ROW_FIELD_W-1:0] cursor_row;
        logic [POS_FIELD_W-1:0] cursor_pos;
        logic [15:0]            cell_data;
    } t_result;

endpackage

### sv/text_console_char_writer.sv
// Text console character writer: cell memory, cursor tracking, scroll and clear sequencer.
// Put character, backspace, newline, unused action: result loaded in the cycle taken;
//   read: memory word registered first; clear: every cell filled; scrolling put: rows
//   copied up, bottom row filled. One item at a time, taken once the last is done and
//   the output is free; the scroll copy runs one cell per cycle in the single memory.
// Reset (synchronous, active low) homes the cursor, sets the color to 0x0F and then sweeps
//   the cell memory with blanks, during which no item is taken.
`timescale 1ns / 1ps

module text_console_char_writer #(
    parameter int COLUMNS = tccw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tccw_pkg::DEF_ROWS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  tccw_pkg::t_item  i_in_item,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output tccw_pkg::t_result o_out_item,
    input  logic             i_cfg_we,
    input  logic [7:0]       i_cfg_data
);

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int ADDR_W = $clog2(CELLS);

    // Widths used to extend or truncate internal values against the port fields.
    localparam int OC_W = (COL_W > tccw_pkg::COL_FIELD_W) ? COL_W : tccw_pkg::COL_FIELD_W;
    localparam int OR_W = (ROW_W > tccw_pkg::ROW_FIELD_W) ? ROW_W : tccw_pkg::ROW_FIELD_W;
    localparam int OP_W = (ADDR_W > tccw_pkg::POS_FIELD_W) ? ADDR_W : tccw_pkg::POS_FIELD_W;
    localparam int AX_W = (ADDR_W > tccw_pkg::ADR_FIELD_W) ? ADDR_W : tccw_pkg::ADR_FIELD_W;

    // Sequencer states. S_FILL serves the reset sweep, a clear and the bottom row
    // of a scroll; S_SCROLL copies every row but the top one up by one.
    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_READ   = 4'b0010,
        S_SCROLL = 4'b0100,
        S_FILL   = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // Cursor kept both as column/row and as a linear cell index, so that no
    // multiplication is needed to address the memory.
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [ADDR_W-1:0] r_pos, n_pos;

    logic [7:0]        r_text_color;

    // Write pointer of the fill and of the copy, read pointer of the copy.
    logic [ADDR_W-1:0] r_ptr, n_ptr;
    logic [ADDR_W-1:0] r_src, n_src;
    logic              r_src_act, n_src_act;
    logic              r_cp_pend, n_cp_pend;
    logic [15:0]       r_fill_data, n_fill_data;
    logic              r_fill_report, n_fill_report;
    logic              r_rd_in_range, n_rd_in_range;

    // The cell memory: one write port and one registered read port.
    logic [15:0]       r_mem [CELLS];
    logic [15:0]       r_rd_data;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [15:0]       mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;

    // Output register.
    logic              r_out_valid;
    tccw_pkg::t_result r_out;
    logic              out_load;
    logic [15:0]       n_cell_data;
    tccw_pkg::t_result n_result;

    logic              accept;
    logic [AX_W-1:0]   addr_ext;
    logic [15:0]       blank;
    logic              wrap;
    logic [OC_W-1:0]   col_ext;
    logic [OR_W-1:0]   row_ext;
    logic [OP_W-1:0]   pos_ext;

    // An item enters only when the sequencer is idle and the output register is
    // free, or is being emptied in this very cycle.
    assign o_in_stall = !((r_state == S_IDLE) && (!r_out_valid || !i_out_stall));
    assign accept     = i_in_valid && !o_in_stall;
    assign addr_ext   = AX_W'(i_in_item.cell_address);
    assign blank      = {r_text_color, tccw_pkg::CHAR_SPACE};

    always_comb begin
        n_state       = r_state;
        n_col         = r_col;
        n_row         = r_row;
        n_pos         = r_pos;
        n_ptr         = r_ptr;
        n_src         = r_src;
        n_src_act     = r_src_act;
        n_cp_pend     = r_cp_pend;
        n_fill_data   = r_fill_data;
        n_fill_report = r_fill_report;
        n_rd_in_range = r_rd_in_range;
        n_cell_data   = '0;
        out_load      = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = r_ptr;
        mem_wdata     = r_fill_data;
        mem_re        = 1'b0;
        mem_raddr     = r_src;
        wrap          = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_in_item.action)
                        tccw_pkg::ACT_PUT: begin
                            if (i_in_item.char_code == tccw_pkg::CHAR_BACKSPACE) begin
                                // The cell left of the cursor is always pos - 1, also
                                // when stepping back to the end of the previous row.
                                if (r_col != '0) begin
                                    n_col     = r_col - 1'b1;
                                    n_pos     = r_pos - 1'b1;
                                    mem_we    = 1'b1;
                                    mem_waddr = r_pos - 1'b1;
                                    mem_wdata = blank;
                                end else if (r_row != '0) begin
                                    n_col     = COL_W'(COLUMNS - 1);
                                    n_row     = r_row - 1'b1;
                                    n_pos     = r_pos - 1'b1;
                                    mem_we    = 1'b1;
                                    mem_waddr = r_pos - 1'b1;
                                    mem_wdata = blank;
                                end
                                out_load = 1'b1;
                            end else begin
                                if (i_in_item.char_code == tccw_pkg::CHAR_NEWLINE) begin
                                    wrap = 1'b1;
                                end else begin
                                    mem_we    = 1'b1;
                                    mem_waddr = r_pos;
                                    mem_wdata = {r_text_color, i_in_item.char_code};
                                    wrap      = (r_col == COL_W'(COLUMNS - 1));
                                end
                                if (!wrap) begin
                                    n_col    = r_col + 1'b1;
                                    n_pos    = r_pos + 1'b1;
                                    out_load = 1'b1;
                                end else if (r_row == ROW_W'(ROWS - 1)) begin
                                    // Past the last row: copy rows up, then blank the
                                    // bottom row; the result follows the fill.
                                    n_col         = '0;
                                    n_row         = ROW_W'(ROWS - 1);
                                    n_pos         = ADDR_W'((ROWS - 1) * COLUMNS);
                                    n_src         = ADDR_W'(COLUMNS);
                                    n_src_act     = 1'b1;
                                    n_cp_pend     = 1'b0;
                                    n_ptr         = '0;
                                    n_fill_data   = blank;
                                    n_fill_report = 1'b1;
                                    n_state       = S_SCROLL;
                                end else begin
                                    n_col    = '0;
                                    n_row    = r_row + 1'b1;
                                    n_pos    = r_pos - ADDR_W'(r_col) + ADDR_W'(COLUMNS);
                                    out_load = 1'b1;
                                end
                            end
                        end
                        tccw_pkg::ACT_CLEAR: begin
                            n_col         = '0;
                            n_row         = '0;
                            n_pos         = '0;
                            n_ptr         = '0;
                            n_fill_data   = blank;
                            n_fill_report = 1'b1;
                            n_state       = S_FILL;
                        end
                        tccw_pkg::ACT_READ: begin
                            mem_re        = 1'b1;
                            mem_raddr     = addr_ext[ADDR_W-1:0];
                            n_rd_in_range = (addr_ext < AX_W'(CELLS));
                            n_state       = S_READ;
                        end
                        default: begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_cell_data = r_rd_in_range ? r_rd_data : 16'h0000;
                out_load    = 1'b1;
                n_state     = S_IDLE;
            end
            S_SCROLL: begin
                // Reads run COLUMNS cells ahead of the writes, so a cell is always
                // read before the copy overwrites it.
                if (r_src_act) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_src;
                    n_src     = r_src + 1'b1;
                    if (r_src == ADDR_W'(CELLS - 1)) begin
                        n_src_act = 1'b0;
                    end
                end
                n_cp_pend = r_src_act;
                if (r_cp_pend) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_ptr;
                    mem_wdata = r_rd_data;
                    n_ptr     = r_ptr + 1'b1;
                end
                if (!r_src_act && !r_cp_pend) begin
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                mem_we    = 1'b1;
                mem_waddr = r_ptr;
                mem_wdata = r_fill_data;
                n_ptr     = r_ptr + 1'b1;
                if (r_ptr == ADDR_W'(CELLS - 1)) begin
                    out_load = r_fill_report;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Result fields are the cursor after the step, cut or extended to the port widths.
    assign col_ext = OC_W'(n_col);
    assign row_ext = OR_W'(n_row);
    assign pos_ext = OP_W'(n_pos);

    always_comb begin
        n_result.cursor_column = col_ext[tccw_pkg::COL_FIELD_W-1:0];
        n_result.cursor_row    = row_ext[tccw_pkg::ROW_FIELD_W-1:0];
        n_result.cursor_pos    = pos_ext[tccw_pkg::POS_FIELD_W-1:0];
        n_result.cell_data     = n_cell_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_FILL;
            r_col         <= '0;
            r_row         <= '0;
            r_pos         <= '0;
            r_ptr         <= '0;
            r_src         <= '0;
            r_src_act     <= 1'b0;
            r_cp_pend     <= 1'b0;
            r_fill_data   <= {tccw_pkg::RESET_COLOR, tccw_pkg::CHAR_SPACE};
            r_fill_report <= 1'b0;
            r_rd_in_range <= 1'b0;
            r_text_color  <= tccw_pkg::RESET_COLOR;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_col         <= n_col;
            r_row         <= n_row;
            r_pos         <= n_pos;
            r_ptr         <= n_ptr;
            r_src         <= n_src;
            r_src_act     <= n_src_act;
            r_cp_pend     <= n_cp_pend;
            r_fill_data   <= n_fill_data;
            r_fill_report <= n_fill_report;
            r_rd_in_range <= n_rd_in_range;
            if (i_cfg_we) begin
                r_text_color <= i_cfg_data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_raddr];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef SYNTHESIS
    // No item may enter while the sequencer is busy.
    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_in_stall)
        else $error("item input open while the sequencer is busy");

    // The cursor stays on the screen.
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col <= COL_W'(COLUMNS - 1)) && (r_row <= ROW_W'(ROWS - 1)))
        else $error("cursor left the screen");

    // An accepted read goes to the read state and never writes the memory there.
    a_read_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_in_item.action == tccw_pkg::ACT_READ)) |=>
        ((r_state == S_READ) && !mem_we))
        else $error("read item did not take the read path");

    // The scroll copy hands over to the fill at the start of the bottom row.
    a_scroll_to_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SCROLL) && !r_src_act && !r_cp_pend) |->
        (r_ptr == ADDR_W'((ROWS - 1) * COLUMNS)))
        else $error("scroll copy ended at the wrong cell");
`endif

endmodule
